[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property templates for concurrent checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MDU_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define MDU_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[sv/mdu_pkg.sv]
// ---------------------------------------------------------------------------
// mdu_pkg
// Types, command codes and helpers of the HI/LO multiply-divide unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mdu_pkg;

  localparam int XLEN   = 64;
  localparam int HALF   = 32;
  localparam int AW     = XLEN + 1;
  localparam int ITERS  = 64;
  localparam int ITER_W = 6;

  typedef enum logic [3:0] {
    CMD_MULT     = 4'd0,
    CMD_MULTU    = 4'd1,
    CMD_DIV      = 4'd2,
    CMD_DIVU     = 4'd3,
    CMD_DMULT    = 4'd4,
    CMD_DMULTU   = 4'd5,
    CMD_DDIV     = 4'd6,
    CMD_DDIVU    = 4'd7,
    CMD_WRITE_HI = 4'd8,
    CMD_WRITE_LO = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [3:0]      cmd;
    logic [XLEN-1:0] operand_a;
    logic [XLEN-1:0] operand_b;
  } src_item_t;

  typedef struct packed {
    logic [XLEN-1:0] hi_value;
    logic [XLEN-1:0] lo_value;
  } res_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORR_A,
    ST_CORR_B,
    ST_ABS_N,
    ST_ABS_D,
    ST_DIV,
    ST_FIX_Q,
    ST_FIX_R,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic load;
    logic mul_step;
    logic corr_a;
    logic corr_b;
    logic abs_n;
    logic abs_d;
    logic div_step;
    logic fix_q;
    logic fix_r;
    logic commit;
  } ctl_t;

  function automatic logic [XLEN-1:0] sext32(logic [XLEN-1:0] v);
    return {{(XLEN-HALF){v[HALF-1]}}, v[HALF-1:0]};
  endfunction

  // 32-bit forms work on the low word, sign- or zero-extended.
  function automatic logic [XLEN-1:0] ext_operand(logic [3:0] cmd, logic [XLEN-1:0] v);
    logic [XLEN-1:0] r;
    case (cmd)
      CMD_MULT, CMD_DIV:   r = sext32(v);
      CMD_MULTU, CMD_DIVU: r = {{(XLEN-HALF){1'b0}}, v[HALF-1:0]};
      default:             r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/mdu_alu.sv]
// ---------------------------------------------------------------------------
// mdu_alu
// Shared 65-bit add/subtract unit with carry out, used by every step.
// ---------------------------------------------------------------------------
`default_nettype none

module mdu_alu
  import mdu_pkg::*;
(
  input  wire logic [AW-1:0] x,
  input  wire logic [AW-1:0] y,
  input  wire logic          sub,
  output logic      [AW:0]   sum
);

  logic [AW-1:0] y_op;

  assign y_op = sub ? ~y : y;
  assign sum  = {1'b0, x} + {1'b0, y_op} + {{AW{1'b0}}, sub};

endmodule

`default_nettype wire

[sv/mdu_seq.sv]
// ---------------------------------------------------------------------------
// mdu_seq
// Sequencer: steps the shared adder through multiply or divide commands.
// ---------------------------------------------------------------------------
`default_nettype none

module mdu_seq
  import mdu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       src_valid,
  input  wire logic [3:0] cmd,
  input  wire logic       res_free,
  output ctl_t            ctl
);

  state_t            state;
  state_t            state_next;
  logic [ITER_W-1:0] cnt;
  logic              last;

  assign last = (cnt == ITER_W'(ITERS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Wraps back to zero after the last iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.mul_step || ctl.div_step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.busy   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (src_valid) begin
          ctl.load = 1'b1;
          if (cmd inside {CMD_MULT, CMD_MULTU, CMD_DMULT, CMD_DMULTU}) begin
            state_next = ST_MUL;
          end else if (cmd inside {CMD_DIV, CMD_DIVU, CMD_DDIV, CMD_DDIVU}) begin
            state_next = ST_ABS_N;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        ctl.mul_step = 1'b1;
        if (last) state_next = ST_CORR_A;
      end
      ST_CORR_A: begin
        ctl.corr_a = 1'b1;
        state_next = ST_CORR_B;
      end
      ST_CORR_B: begin
        ctl.corr_b = 1'b1;
        state_next = ST_DONE;
      end
      ST_ABS_N: begin
        ctl.abs_n  = 1'b1;
        state_next = ST_ABS_D;
      end
      ST_ABS_D: begin
        ctl.abs_d  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (last) state_next = ST_FIX_Q;
      end
      ST_FIX_Q: begin
        ctl.fix_q  = 1'b1;
        state_next = ST_FIX_R;
      end
      ST_FIX_R: begin
        ctl.fix_r  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register can take the transfer
        if (res_free) begin
          ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/multiply_divide_hi_lo_unit.sv]
// ---------------------------------------------------------------------------
// multiply_divide_hi_lo_unit
// HI/LO multiply-divide unit: 32/64-bit signed and unsigned multiply and
// divide, plus HI and LO writes; every command returns HI and LO.
// ---------------------------------------------------------------------------
// One command at a time. Multiplies run 64 shift-add steps plus two signed
// corrections before the result register is loaded; divides run two
// magnitude steps, 64 restoring steps and two sign fixes; HI/LO writes and
// unused codes go straight to the result load. A new command is taken the cycle
// after the result is loaded, even if that result is still stalled. The
// single 65-bit adder retires one product or quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"

module multiply_divide_hi_lo_unit
  import mdu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_stall,
  input  wire src_item_t src_item,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_item_t      res_item
);

  ctl_t            ctl;
  logic            res_free;

  logic [XLEN-1:0] hi_reg;
  logic [XLEN-1:0] lo_reg;
  logic [XLEN-1:0] a_reg;
  logic [XLEN-1:0] dreg;
  logic [XLEN-1:0] qreg;
  logic [XLEN-1:0] acc;
  logic [3:0]      cmd_reg;
  logic            neg_n;
  logic            neg_d;

  logic [XLEN-1:0] a_ext;
  logic [XLEN-1:0] b_ext;
  logic            div_signed;
  logic            dmult_cmd;

  logic [AW-1:0]   alu_x;
  logic [AW-1:0]   alu_y;
  logic            alu_sub;
  logic [AW:0]     alu_sum;
  logic [AW-1:0]   mul_sum;

  logic [XLEN-1:0] hi_next;
  logic [XLEN-1:0] lo_next;

  assign res_free   = !res_valid || !res_stall;
  assign src_stall  = ctl.busy;
  assign a_ext      = ext_operand(src_item.cmd, src_item.operand_a);
  assign b_ext      = ext_operand(src_item.cmd, src_item.operand_b);
  assign div_signed = (src_item.cmd == CMD_DIV) || (src_item.cmd == CMD_DDIV);
  assign dmult_cmd  = (cmd_reg == CMD_DMULT);

  mdu_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .cmd       (src_item.cmd),
    .res_free  (res_free),
    .ctl       (ctl)
  );

  mdu_alu u_alu (
    .x   (alu_x),
    .y   (alu_y),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  // Operand routing for the shared adder.
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    if (ctl.mul_step) begin
      alu_x = {1'b0, acc};
      alu_y = {1'b0, dreg};
    end else if (ctl.div_step) begin
      alu_x   = {acc, qreg[XLEN-1]};
      alu_y   = {1'b0, dreg};
      alu_sub = 1'b1;
    end else if (ctl.abs_n || ctl.fix_q) begin
      alu_y   = {1'b0, qreg};
      alu_sub = 1'b1;
    end else if (ctl.abs_d) begin
      alu_y   = {1'b0, dreg};
      alu_sub = 1'b1;
    end else if (ctl.fix_r) begin
      alu_y   = {1'b0, acc};
      alu_sub = 1'b1;
    end else if (ctl.corr_a) begin
      alu_x   = {1'b0, acc};
      alu_y   = {1'b0, dreg};
      alu_sub = 1'b1;
    end else if (ctl.corr_b) begin
      alu_x   = {1'b0, acc};
      alu_y   = {1'b0, a_reg};
      alu_sub = 1'b1;
    end
  end

  assign mul_sum = qreg[0] ? alu_sum[AW-1:0] : {1'b0, acc};

  // Datapath registers; payload only, no reset.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_reg   <= a_ext;
      dreg    <= b_ext;
      qreg    <= a_ext;
      acc     <= '0;
      cmd_reg <= src_item.cmd;
      neg_n   <= div_signed && a_ext[XLEN-1];
      neg_d   <= div_signed && b_ext[XLEN-1];
    end
    if (ctl.mul_step) begin
      acc  <= mul_sum[AW-1:1];
      qreg <= {mul_sum[0], qreg[XLEN-1:1]};
    end
    if (ctl.div_step) begin
      // carry out set: partial remainder covers the divisor
      acc  <= alu_sum[AW] ? alu_sum[XLEN-1:0] : {acc[XLEN-2:0], qreg[XLEN-1]};
      qreg <= {qreg[XLEN-2:0], alu_sum[AW]};
    end
    if (ctl.abs_n && neg_n) qreg <= alu_sum[XLEN-1:0];
    if (ctl.abs_d && neg_d) dreg <= alu_sum[XLEN-1:0];
    if (ctl.fix_q && (neg_n != neg_d)) qreg <= alu_sum[XLEN-1:0];
    if (ctl.fix_r && neg_n) acc <= alu_sum[XLEN-1:0];
    // signed 64-bit product: high half minus the other operand per negative one
    if (ctl.corr_a && dmult_cmd && a_reg[XLEN-1]) acc <= alu_sum[XLEN-1:0];
    if (ctl.corr_b && dmult_cmd && dreg[XLEN-1]) acc <= alu_sum[XLEN-1:0];
  end

  always_comb begin
    hi_next = hi_reg;
    lo_next = lo_reg;
    case (cmd_reg)
      CMD_MULT, CMD_MULTU: begin
        hi_next = sext32({{HALF{1'b0}}, qreg[XLEN-1:HALF]});
        lo_next = sext32(qreg);
      end
      CMD_DIVU: begin
        hi_next = sext32(acc);
        lo_next = sext32(qreg);
      end
      CMD_DIV, CMD_DMULT, CMD_DMULTU, CMD_DDIV, CMD_DDIVU: begin
        hi_next = acc;
        lo_next = qreg;
      end
      CMD_WRITE_HI: hi_next = a_reg;
      CMD_WRITE_LO: lo_next = a_reg;
      default: begin
        hi_next = hi_reg;
        lo_next = lo_reg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_reg <= '0;
      lo_reg <= '0;
    end else if (ctl.commit) begin
      hi_reg <= hi_next;
      lo_reg <= lo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      res_item.hi_value <= hi_next;
      res_item.lo_value <= lo_next;
    end
  end

  `MDU_ASSERT_NEXT(a_busy_after_accept, src_valid && !src_stall, src_stall,
    "unit accepted a command but did not go busy")

  `MDU_ASSERT_NOW(a_commit_needs_room, ctl.commit, !res_valid || !res_stall,
    "result committed over a stalled result")

  `MDU_ASSERT_NEXT(a_result_matches_regs, ctl.commit,
    res_valid && (res_item.hi_value == hi_reg) && (res_item.lo_value == lo_reg),
    "result register disagrees with HI/LO after commit")

endmodule

`default_nettype wire
